[rtl/mrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring deque package
// Shared widths, operation and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package mrd_pkg;

    localparam int DEPTH_DEF   = 256;
    localparam int MSG_W_DEF   = 64;

    localparam int OP_W        = 2;
    localparam int MSG_FIELD_W = 64;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 9;
    localparam int COUNT_W     = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    typedef enum logic [OP_W-1:0] {
        OP_POST_TAIL = 2'd0,
        OP_POST_HEAD = 2'd1,
        OP_ACCEPT    = 2'd2,
        OP_FLUSH     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[rtl/mrd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring deque controller
// Sequences one word through take, execute and result load.
// ----------------------------------------------------------------------------
module mrd_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire mrd_pkg::stat_t stat,
    output mrd_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.load   = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/mrd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring deque datapath
// Ring memory, head/tail indices, held count, capacity and result register.
// ----------------------------------------------------------------------------
module mrd_datapath
#(
    parameter int RING_DEPTH    = mrd_pkg::DEPTH_DEF,
    parameter int MESSAGE_WIDTH = mrd_pkg::MSG_W_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mrd_pkg::cmd_t                   cmd,
    output mrd_pkg::stat_t                       stat,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mrd_pkg::CAP_W-1:0]       cfg_wr_data,
    input  wire logic [mrd_pkg::OP_W-1:0]        operation,
    input  wire logic [mrd_pkg::MSG_FIELD_W-1:0] message_in,
    input  wire logic                            m_tready,
    output logic                                 out_valid,
    output logic [mrd_pkg::STATUS_W-1:0]         status,
    output logic [mrd_pkg::MSG_FIELD_W-1:0]      message_out,
    output logic [mrd_pkg::COUNT_W-1:0]          entry_count
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CMP_W = (IDX_W + 1 > mrd_pkg::CAP_W) ? IDX_W + 1 : mrd_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(RING_DEPTH);

    logic [MESSAGE_WIDTH-1:0] ring_mem [RING_DEPTH];

    logic [mrd_pkg::CAP_W-1:0]   cap_reg;
    logic [IDX_W-1:0]            head_reg;
    logic [IDX_W-1:0]            head_next;
    logic [IDX_W-1:0]            tail_reg;
    logic [IDX_W-1:0]            tail_next;
    logic [mrd_pkg::COUNT_W-1:0] count_reg;
    logic [mrd_pkg::COUNT_W-1:0] count_next;
    mrd_pkg::op_t                op_reg;
    logic [MESSAGE_WIDTH-1:0]    msg_reg;
    logic [MESSAGE_WIDTH-1:0]    rd_data_reg;
    logic                        taken_reg;
    logic                        taken_next;
    mrd_pkg::status_t            res_status_reg;
    mrd_pkg::status_t            res_status_next;
    logic                        out_valid_reg;
    logic [mrd_pkg::STATUS_W-1:0]    out_status_reg;
    logic [mrd_pkg::MSG_FIELD_W-1:0] out_msg_reg;
    logic [mrd_pkg::COUNT_W-1:0]     out_count_reg;

    logic [CMP_W-1:0] cap_raw_w;
    logic [CMP_W-1:0] cap_w;
    logic [CMP_W-1:0] head_w;
    logic [CMP_W-1:0] tail_inc_w;
    logic [CMP_W-1:0] head_inc_w;
    logic [CMP_W-1:0] head_dec_w;
    logic [CMP_W-1:0] count_w;
    logic             is_full;
    logic             is_empty;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;

    always_comb
    begin
        cap_raw_w = CMP_W'(cap_reg);
        if (cap_raw_w == '0)
        begin
            cap_w = CMP_W'(1);
        end
        else if (cap_raw_w > DEPTH_C)
        begin
            cap_w = DEPTH_C;
        end
        else
        begin
            cap_w = cap_raw_w;
        end
        head_w     = CMP_W'(head_reg);
        tail_inc_w = CMP_W'(tail_reg) + CMP_W'(1);
        head_inc_w = head_w + CMP_W'(1);
        if (head_reg == '0 || head_w >= cap_w)
        begin
            head_dec_w = cap_w - CMP_W'(1);
        end
        else
        begin
            head_dec_w = head_w - CMP_W'(1);
        end
        count_w  = CMP_W'(count_reg);
        is_full  = (count_w >= cap_w);
        is_empty = (count_reg == '0);
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        taken_next      = 1'b0;
        res_status_next = mrd_pkg::ST_OK;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        rd_en           = 1'b0;
        case (op_reg)
            mrd_pkg::OP_POST_TAIL:
            begin
                if (is_full)
                begin
                    res_status_next = mrd_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = (tail_inc_w >= cap_w) ? '0 : tail_inc_w[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            mrd_pkg::OP_POST_HEAD:
            begin
                if (is_full)
                begin
                    res_status_next = mrd_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_dec_w[IDX_W-1:0];
                    head_next  = head_dec_w[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            mrd_pkg::OP_ACCEPT:
            begin
                if (is_empty)
                begin
                    res_status_next = mrd_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    taken_next = 1'b1;
                    head_next  = (head_inc_w >= cap_w) ? '0 : head_inc_w[IDX_W-1:0];
                    count_next = count_reg - 1'b1;
                end
            end
            mrd_pkg::OP_FLUSH:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                res_status_next = mrd_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= mrd_pkg::CAP_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            taken_reg      <= 1'b0;
            res_status_reg <= mrd_pkg::ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                head_reg       <= head_next;
                tail_reg       <= tail_next;
                count_reg      <= count_next;
                taken_reg      <= taken_next;
                res_status_reg <= res_status_next;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= mrd_pkg::op_t'(operation);
            msg_reg <= message_in[MESSAGE_WIDTH-1:0];
        end
        if (cmd.exec && wr_en)
        begin
            ring_mem[wr_addr] <= msg_reg;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= ring_mem[head_reg];
        end
        if (cmd.load)
        begin
            out_status_reg <= res_status_reg;
            out_msg_reg    <= taken_reg ? mrd_pkg::MSG_FIELD_W'(rd_data_reg) : '0;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign message_out   = out_msg_reg;
    assign entry_count   = out_count_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over a waiting word");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == mrd_pkg::OP_FLUSH |=>
        count_reg == '0 && head_reg == '0 && tail_reg == '0)
        else $error("flush left ring state");

    a_refused_post: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (op_reg == mrd_pkg::OP_POST_TAIL || op_reg == mrd_pkg::OP_POST_HEAD)
        && is_full |=> count_reg == $past(count_reg) && res_status_reg == mrd_pkg::ST_FULL)
        else $error("refused post changed count");

    a_empty_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == mrd_pkg::OP_ACCEPT && is_empty |=>
        res_status_reg == mrd_pkg::ST_EMPTY && !taken_reg && count_reg == '0)
        else $error("empty accept mishandled");

endmodule
`default_nettype wire

[rtl/message_ring_deque_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Message ring deque core
// Ring of message words with post to tail, post to head, accept and flush.
//
// s_tdata carries one command word: operation and message_in. Each command
// gives exactly one result word on m_tdata: status, message_out, entry_count.
// cfg_wr_en/cfg_wr_data write queue_capacity, the wrap point of the ring;
// write it only while no command is in flight.
// A command moves through the controller steps take, execute (with one ring
// memory access) and result register load; m_tvalid rises from that load.
// One command is in flight at a time, so the next command is taken only once
// the controller sequence around the registered memory read is back in idle.
// The result register lets the next command be taken while a result waits;
// if m_tready stays low, the following result holds in the datapath and
// s_tready stays low until the result register frees.
// Reset empties the ring (indices and count to zero), sets capacity to 256,
// and drops any pending result; ring contents are not cleared.
// ----------------------------------------------------------------------------
module message_ring_deque_core
#(
    parameter int RING_DEPTH    = mrd_pkg::DEPTH_DEF,
    parameter int MESSAGE_WIDTH = mrd_pkg::MSG_W_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mrd_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // operation [1:0], message_in [65:2], zero [71:66]
    input  wire logic [mrd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status [1:0], message_out [65:2], entry_count [74:66], zero [79:75]
    output logic [mrd_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int MSG_LO = mrd_pkg::OP_W;
    localparam int CNT_LO = mrd_pkg::STATUS_W + mrd_pkg::MSG_FIELD_W;
    localparam int PAD_W  = mrd_pkg::M_TDATA_W - CNT_LO - mrd_pkg::COUNT_W;

    mrd_pkg::cmd_t  cmd;
    mrd_pkg::stat_t stat;

    logic [mrd_pkg::STATUS_W-1:0]    status;
    logic [mrd_pkg::MSG_FIELD_W-1:0] message_out;
    logic [mrd_pkg::COUNT_W-1:0]     entry_count;

    mrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mrd_datapath
    #(
        .RING_DEPTH    (RING_DEPTH),
        .MESSAGE_WIDTH (MESSAGE_WIDTH)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .operation   (s_tdata[mrd_pkg::OP_W-1:0]),
        .message_in  (s_tdata[MSG_LO +: mrd_pkg::MSG_FIELD_W]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .status      (status),
        .message_out (message_out),
        .entry_count (entry_count)
    );

    assign m_tdata = {{PAD_W{1'b0}}, entry_count, message_out, status};

endmodule
`default_nettype wire
